// ----- rtl/core/drf_pkg.sv -----
package drf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int OCC_W    = 5;
  localparam int STATUS_W = 3;

  // Command queue between the front and back parts
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic [63:0] name_lo;
    logic [63:0] name_mid;
    logic [31:0] name_hi;
    logic [63:0] title_lo;
    logic [55:0] title_hi;
    logic [7:0]  grade;
    logic [7:0]  age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t  op;
    rec_t rec;
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 3'd0,
    ST_DUP    = 3'd1,
    ST_POPPED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EXEC
  } bk_state_t;

endpackage

// ----- rtl/core/drf_ram.sv -----
module drf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/drf_front.sv -----
module drf_front import drf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic mode,
  input  rec_t rec_in,
  output logic busy,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic head_take
);

  cmd_t                slot [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] fill;
  logic [CQ_CNT_W-1:0] fill_next;
  logic                accept;
  cmd_t                new_cmd;

  function automatic logic [CQ_PTR_W-1:0] cq_advance(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy       = (fill == CQ_CNT_W'(CMDQ_DEPTH));
  assign accept     = start && !busy;
  assign head_valid = (fill != '0);
  assign head_cmd   = slot[rd_ptr];

  // Classify: pops carry no record, so blank it
  always_comb begin
    new_cmd.op  = op_t'(mode);
    new_cmd.rec = (new_cmd.op == OP_POP) ? '0 : rec_in;
  end

  always_comb begin
    case ({accept, head_take})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= cq_advance(wr_ptr);
      end
      if (head_take) begin
        rd_ptr <= cq_advance(rd_ptr);
      end
      fill <= fill_next;
    end
  end

endmodule

// ----- rtl/core/drf_back.sv -----
module drf_back import drf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cmd_t             head_cmd,
  output logic             head_take,
  output logic             done,
  output status_t          status,
  output logic [OCC_W-1:0] occupancy
);

  bk_state_t        state;
  bk_state_t        state_next;
  cmd_t             cmd;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] scan_addr;
  logic [PTR_W-1:0] scan_addr_next;
  logic [CNT_W-1:0] issued;
  logic [CNT_W-1:0] issued_next;
  logic             rd_pend;
  logic             rd_pend_next;
  logic             dup;
  logic             dup_next;
  logic             done_next;
  status_t          status_next;
  logic [OCC_W-1:0] occupancy_next;

  logic             ram_re;
  logic             ram_we;
  logic [REC_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  drf_ram #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (cmd.rec),
    .re    (ram_re),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    count_next     = count;
    scan_addr_next = scan_addr;
    issued_next    = issued;
    rd_pend_next   = 1'b0;
    dup_next       = dup;
    done_next      = 1'b0;
    status_next    = status;
    occupancy_next = occupancy;
    head_take      = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;

    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          head_take      = 1'b1;
          scan_addr_next = rd_ptr;
          issued_next    = '0;
          dup_next       = 1'b0;
          state_next     = (head_cmd.op == OP_POP) ? BK_EXEC : BK_SCAN;
        end
      end
      BK_SCAN: begin
        // Issue one read per held record; compare the returned data in the following cycle
        if (rd_pend && (rec_t'(ram_rdata) == cmd.rec)) begin
          dup_next = 1'b1;
        end
        if (issued != count) begin
          ram_re         = 1'b1;
          rd_pend_next   = 1'b1;
          scan_addr_next = ptr_advance(scan_addr);
          issued_next    = issued + 1'b1;
        end else begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        done_next  = 1'b1;
        state_next = BK_IDLE;
        if (cmd.op == OP_POP) begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            rd_ptr_next = ptr_advance(rd_ptr);
            count_next  = count - 1'b1;
            status_next = ST_POPPED;
          end
        end else if (dup) begin
          status_next = ST_DUP;
        end else if (count == CNT_W'(QUEUE_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ram_we      = 1'b1;
          wr_ptr_next = ptr_advance(wr_ptr);
          count_next  = count + 1'b1;
          status_next = ST_PUSHED;
        end
        occupancy_next = OCC_W'(count_next);
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      cmd <= head_cmd;
    end
    scan_addr <= scan_addr_next;
    issued    <= issued_next;
    dup       <= dup_next;
    status    <= status_next;
    occupancy <= occupancy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      count   <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_ptr  <= rd_ptr_next;
      wr_ptr  <= wr_ptr_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
      done    <= done_next;
    end
  end

endmodule

// ----- rtl/core/dedup_record_fifo_core.sv -----
// A pop is reported once the back part takes it from the command queue and executes it; a push
// first scans the N records held (one record RAM read per cycle for the scan) before executing.
// The back part works on one transaction at a time, and the scan through the single read port
// of the record RAM sets how long a push takes; a two-entry command queue absorbs bursts.
// Reset (rst, synchronous) empties the queue and clears pointers and count; record RAM
// contents are not cleared. Results are strobed on done; the receiver cannot stall.
module dedup_record_fifo_core import drf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic [63:0]         name_bytes_lo,
  input  logic [63:0]         name_bytes_mid,
  input  logic [31:0]         name_bytes_hi,
  input  logic [63:0]         title_bytes_lo,
  input  logic [55:0]         title_bytes_hi,
  input  logic [7:0]          grade_value,
  input  logic [7:0]          age_value,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [OCC_W-1:0]    occupancy
);

  rec_t    rec_in;
  logic    head_valid;
  cmd_t    head_cmd;
  logic    head_take;
  status_t status_int;

  always_comb begin
    rec_in.name_lo  = name_bytes_lo;
    rec_in.name_mid = name_bytes_mid;
    rec_in.name_hi  = name_bytes_hi;
    rec_in.title_lo = title_bytes_lo;
    rec_in.title_hi = title_bytes_hi;
    rec_in.grade    = grade_value;
    rec_in.age      = age_value;
  end

  drf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .rec_in     (rec_in),
    .busy       (busy),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_take  (head_take)
  );

  drf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_take  (head_take),
    .done       (done),
    .status     (status_int),
    .occupancy  (occupancy)
  );

  assign status = status_int;

`ifndef SYNTH
  a_take_needs_head: assert property (@(posedge clk) disable iff (rst)
    head_take |-> head_valid)
    else $error("back took a transaction from an empty command queue");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status_int == ST_EMPTY)) |-> (occupancy == '0))
    else $error("pop on empty reported nonzero occupancy");
`endif

endmodule
